>>> rtl/core/blmr_pkg.sv
package blmr_pkg;

   localparam int COLS_PER_BP   = 8;
   localparam int BACKPACKS_DEF = 2;
   localparam int ROWS_DEF      = 8;

   localparam logic CSR_GREEN_MASK = 1'b0;
   localparam logic CSR_BRIGHTNESS = 1'b1;

   typedef enum logic [1:0] {
      ACT_DRAW  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_INIT  = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] column;
      logic [3:0] row;
      logic [1:0] color;
   } req_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } rsp_type;

   // Start request from the front end to the sequencer.
   typedef struct packed {
      logic go;
      logic from_init;
      logic zero;
   } seq_cmd_type;

   localparam logic [6:0] ADDR_BASE = 7'h70;
   localparam logic [2:0] ADDR_MASK = 3'h7;
   localparam logic [3:0] CMD_OSC   = 4'b0010;
   localparam logic [3:0] CMD_DISP  = 4'b1000;
   localparam logic [3:0] CMD_DIM   = 4'b1110;
   localparam logic [3:0] VAL_ON    = 4'b0001;
   localparam logic [7:0] RAM_START = 8'h00;

   function automatic logic [7:0] addr_byte(input logic [2:0] a);
      return {ADDR_BASE | {4'b0000, a & ADDR_MASK}, 1'b0};
   endfunction

   function automatic logic [7:0] cmd_byte(input logic [3:0] cmd, input logic [3:0] val);
      return {cmd, val};
   endfunction

endpackage

>>> rtl/core/blmr_seq.sv
module blmr_seq #(
   parameter int BACKPACKS = blmr_pkg::BACKPACKS_DEF,
   localparam int STORE_AW = $clog2(BACKPACKS * blmr_pkg::COLS_PER_BP)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  blmr_pkg::seq_cmd_type cmd,
   input  logic [7:0]            red_rd,
   input  logic [7:0]            green_rd,
   input  logic [7:0]            green_mask,
   input  logic [3:0]            brightness,
   output logic [STORE_AW-1:0]   rd_idx,
   output logic                  busy,
   output logic                  rsp_valid,
   output blmr_pkg::rsp_type     rsp_data,
   input  logic                  rsp_stall
);

   localparam int BP_W  = (BACKPACKS > 1) ? $clog2(BACKPACKS) : 1;
   localparam int COL_W = $clog2(blmr_pkg::COLS_PER_BP);
   localparam int PC_W  = 4;

   localparam logic [PC_W-1:0] PC_INIT  = 4'd0;
   localparam logic [PC_W-1:0] PC_DIM   = 4'd5;
   localparam logic [PC_W-1:0] PC_FRAME = 4'd6;
   localparam logic [PC_W-1:0] PC_GREEN = 4'd8;

   typedef enum logic [2:0] {
      SRC_ADDR, SRC_OSC, SRC_DISP, SRC_DIM, SRC_RAM_START, SRC_GREEN, SRC_RED
   } src_type;

   typedef enum logic [1:0] {STOP_NONE, STOP_ALWAYS, STOP_COL_LAST} stop_type;

   typedef enum logic [1:0] {JMP_NEXT, JMP_BP, JMP_COL_BP} jump_type;

   typedef struct packed {
      src_type         src;
      logic            start;
      stop_type        stop;
      jump_type        jump;
      logic [PC_W-1:0] tgt_a;
      logic [PC_W-1:0] tgt_b;
   } ctl_word_type;

   function automatic ctl_word_type mk(input src_type s, input logic st, input stop_type sp,
                                       input jump_type j, input logic [PC_W-1:0] a,
                                       input logic [PC_W-1:0] b);
      ctl_word_type w;
      w.src   = s;
      w.start = st;
      w.stop  = sp;
      w.jump  = j;
      w.tgt_a = a;
      w.tgt_b = b;
      return w;
   endfunction

   // Program: init commands per backpack, then the frame loop that clear shares.
   function automatic ctl_word_type rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      unique case (pc)
         4'd0:    w = mk(SRC_ADDR,      1'b1, STOP_NONE,     JMP_NEXT,   '0,       '0);
         4'd1:    w = mk(SRC_OSC,       1'b0, STOP_ALWAYS,   JMP_NEXT,   '0,       '0);
         4'd2:    w = mk(SRC_ADDR,      1'b1, STOP_NONE,     JMP_NEXT,   '0,       '0);
         4'd3:    w = mk(SRC_DISP,      1'b0, STOP_ALWAYS,   JMP_NEXT,   '0,       '0);
         4'd4:    w = mk(SRC_ADDR,      1'b1, STOP_NONE,     JMP_NEXT,   '0,       '0);
         PC_DIM:  w = mk(SRC_DIM,       1'b0, STOP_ALWAYS,   JMP_BP,     PC_INIT,  PC_FRAME);
         PC_FRAME:w = mk(SRC_ADDR,      1'b1, STOP_NONE,     JMP_NEXT,   '0,       '0);
         4'd7:    w = mk(SRC_RAM_START, 1'b0, STOP_NONE,     JMP_NEXT,   '0,       '0);
         PC_GREEN:w = mk(SRC_GREEN,     1'b0, STOP_NONE,     JMP_NEXT,   '0,       '0);
         4'd9:    w = mk(SRC_RED,       1'b0, STOP_COL_LAST, JMP_COL_BP, PC_GREEN, PC_FRAME);
         default: w = mk(SRC_ADDR,      1'b1, STOP_NONE,     JMP_NEXT,   '0,       '0);
      endcase
      return w;
   endfunction

   logic              busy_ff;
   logic              zero_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [COL_W-1:0]  col_ff;
   logic [BP_W-1:0]   bp_ff;
   logic              rsp_valid_ff;
   blmr_pkg::rsp_type rsp_data_ff;

   ctl_word_type      word;
   logic              col_last;
   logic              bp_last;
   logic              step;
   logic [7:0]        byte_sel;
   blmr_pkg::rsp_type rsp_in;

   assign word     = rom(pc_ff);
   assign col_last = (col_ff == COL_W'(blmr_pkg::COLS_PER_BP - 1));
   assign bp_last  = (bp_ff == BP_W'(BACKPACKS - 1));
   assign step     = busy_ff && (!rsp_valid_ff || !rsp_stall);
   // columns per backpack is a power of two, so {backpack, column} is the store index
   assign rd_idx   = STORE_AW'({bp_ff, col_ff});

   always_comb begin
      unique case (word.src)
         SRC_ADDR:      byte_sel = blmr_pkg::addr_byte(3'(bp_ff));
         SRC_OSC:       byte_sel = blmr_pkg::cmd_byte(blmr_pkg::CMD_OSC, blmr_pkg::VAL_ON);
         SRC_DISP:      byte_sel = blmr_pkg::cmd_byte(blmr_pkg::CMD_DISP, blmr_pkg::VAL_ON);
         SRC_DIM:       byte_sel = blmr_pkg::cmd_byte(blmr_pkg::CMD_DIM, brightness);
         SRC_RAM_START: byte_sel = blmr_pkg::RAM_START;
         SRC_GREEN:     byte_sel = zero_ff ? 8'h00 : (green_rd ^ green_mask);
         SRC_RED:       byte_sel = zero_ff ? 8'h00 : red_rd;
         default:       byte_sel = 8'h00;
      endcase
      rsp_in.bus_byte     = byte_sel;
      rsp_in.start_before = word.start;
      rsp_in.stop_after   = (word.stop == STOP_ALWAYS) ||
                            ((word.stop == STOP_COL_LAST) && col_last);
      rsp_in.last         = (word.jump == JMP_COL_BP) && col_last && bp_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         pc_ff        <= PC_INIT;
         col_ff       <= '0;
         bp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.go) begin
            busy_ff <= 1'b1;
            zero_ff <= cmd.zero;
            pc_ff   <= cmd.from_init ? PC_INIT : PC_FRAME;
            col_ff  <= '0;
            bp_ff   <= '0;
         end else if (step) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_in;
            unique case (word.jump)
               JMP_NEXT: begin
                  pc_ff <= pc_ff + PC_W'(1);
               end
               JMP_BP: begin
                  if (!bp_last) begin
                     bp_ff <= bp_ff + BP_W'(1);
                     pc_ff <= word.tgt_a;
                  end else begin
                     bp_ff <= '0;
                     pc_ff <= word.tgt_b;
                  end
               end
               JMP_COL_BP: begin
                  if (!col_last) begin
                     col_ff <= col_ff + COL_W'(1);
                     pc_ff  <= word.tgt_a;
                  end else begin
                     col_ff <= '0;
                     if (!bp_last) begin
                        bp_ff <= bp_ff + BP_W'(1);
                        pc_ff <= word.tgt_b;
                     end else begin
                        bp_ff   <= '0;
                        busy_ff <= 1'b0;
                     end
                  end
               end
               default: begin
                  pc_ff <= pc_ff + PC_W'(1);
               end
            endcase
         end
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/bicolor_led_matrix_refresh_top.sv
// Frame store and two-wire bus byte stream for BACKPACKS 8x8 bicolor LED
// backpacks. A draw item updates one pixel and gives no beat; out-of-range
// pixels are dropped. Clear and frame give 18*BACKPACKS beats, init
// 24*BACKPACKS (three commands per backpack, then a clear). Beats come
// from a microcoded sequencer that steps one control word per beat, so a
// burst runs at one beat per cycle when the result side does not stall.
// A new item is taken only once the sequencer has issued the final beat of
// the previous one; that final beat carries last. Store is cleared by reset.
module bicolor_led_matrix_refresh_top #(
   parameter int BACKPACKS = blmr_pkg::BACKPACKS_DEF,
   parameter int ROWS      = blmr_pkg::ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  blmr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output blmr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);

   localparam int DEPTH    = BACKPACKS * blmr_pkg::COLS_PER_BP;
   localparam int STORE_AW = $clog2(DEPTH);

   logic [7:0]            red_ff   [DEPTH];
   logic [7:0]            green_ff [DEPTH];
   logic [7:0]            mask_ff;
   logic [3:0]            bright_ff;

   logic                  busy;
   logic                  accept;
   logic                  draw_ok;
   logic [STORE_AW-1:0]   wr_idx;
   logic [STORE_AW-1:0]   rd_idx;
   logic [7:0]            row_bit;
   blmr_pkg::seq_cmd_type cmd;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   assign cmd.go        = accept && (req_data.action != blmr_pkg::ACT_DRAW);
   assign cmd.from_init = (req_data.action == blmr_pkg::ACT_INIT);
   assign cmd.zero      = (req_data.action == blmr_pkg::ACT_CLEAR) ||
                          (req_data.action == blmr_pkg::ACT_INIT);

   assign draw_ok = accept && (req_data.action == blmr_pkg::ACT_DRAW) &&
                    (req_data.column < 5'(DEPTH)) && (req_data.row < 4'(ROWS));
   assign wr_idx  = req_data.column[STORE_AW-1:0];
   assign row_bit = 8'(1) << req_data.row[2:0];

   // Clear and init zero the store up front; init's command beats never read the store.
   always_ff @(posedge clock) begin
      if (reset || (cmd.go && cmd.zero)) begin
         for (int i = 0; i < DEPTH; i++) begin
            red_ff[i]   <= 8'h00;
            green_ff[i] <= 8'h00;
         end
      end else if (draw_ok) begin
         red_ff[wr_idx]   <= req_data.color[0] ? (red_ff[wr_idx] | row_bit)
                                               : (red_ff[wr_idx] & ~row_bit);
         green_ff[wr_idx] <= req_data.color[1] ? (green_ff[wr_idx] | row_bit)
                                               : (green_ff[wr_idx] & ~row_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= 8'h00;
         bright_ff <= 4'd6;
      end else if (csr_we) begin
         unique case (csr_index)
            blmr_pkg::CSR_GREEN_MASK: mask_ff   <= csr_wdata;
            blmr_pkg::CSR_BRIGHTNESS: bright_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   blmr_seq #(
      .BACKPACKS(BACKPACKS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .red_rd     (red_ff[rd_idx]),
      .green_rd   (green_ff[rd_idx]),
      .green_mask (mask_ff),
      .brightness (bright_ff),
      .rd_idx     (rd_idx),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.stop_after)
      else $error("last beat does not close a transaction");

   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.start_before && rsp_data.stop_after))
      else $error("beat both opens and closes a transaction");

   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.go |=> req_stall)
      else $error("burst item did not make the block busy");

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_data.last)
      else $error("sequencer went idle without a last beat");

endmodule

>>> tb/bicolor_led_matrix_refresh_top_tb.sv
module bicolor_led_matrix_refresh_top_tb;

   localparam int BP        = blmr_pkg::BACKPACKS_DEF;
   localparam int NUM_ROWS  = blmr_pkg::ROWS_DEF;
   localparam int NUM_COLS  = blmr_pkg::BACKPACKS_DEF * blmr_pkg::COLS_PER_BP;
   localparam int LIMIT     = 1000000;

   typedef struct {
      blmr_pkg::req_type req;
      bit                drain_first;
   } stim_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   blmr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   blmr_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [7:0]        csr_wdata = 8'h00;

   stim_type          pending_q[$];
   blmr_pkg::rsp_type bus_beat_q[$];

   // predicted frame store and registers
   logic [7:0] red_col [NUM_COLS];
   logic [7:0] green_col [NUM_COLS];
   logic [7:0] invert_mask = 8'h00;
   logic [3:0] dim_level = 4'd6;

   int beat_no;
   int beat_total;
   int gap_pct = 26;
   int stall_pct = 81;
   int mismatches = 0;
   int cycles = 0;

   bicolor_led_matrix_refresh_top #(
      .BACKPACKS(BP),
      .ROWS(NUM_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < NUM_COLS; i++) begin
         red_col[i] = 8'h00;
         green_col[i] = 8'h00;
      end
   end

   function automatic logic [7:0] bus_addr(int bp);
      return {blmr_pkg::ADDR_BASE[6:3], 3'(bp), 1'b0};
   endfunction

   function automatic void push_beat(logic [7:0] b, logic st, logic sp);
      blmr_pkg::rsp_type e;
      e.bus_byte = b;
      e.start_before = st;
      e.stop_after = sp;
      e.last = (beat_no == beat_total - 1);
      bus_beat_q.push_back(e);
      beat_no++;
   endfunction

   function automatic void emit_frame(logic zero_data);
      int idx;
      for (int bp = 0; bp < BP; bp++) begin
         push_beat(bus_addr(bp), 1'b1, 1'b0);
         push_beat(blmr_pkg::RAM_START, 1'b0, 1'b0);
         for (int i = 0; i < blmr_pkg::COLS_PER_BP; i++) begin
            idx = bp * blmr_pkg::COLS_PER_BP + i;
            push_beat(zero_data ? 8'h00 : (green_col[idx] ^ invert_mask), 1'b0, 1'b0);
            push_beat(zero_data ? 8'h00 : red_col[idx], 1'b0,
                      i == blmr_pkg::COLS_PER_BP - 1);
         end
      end
   endfunction

   function automatic void wipe_and_emit();
      for (int i = 0; i < NUM_COLS; i++) begin
         red_col[i] = 8'h00;
         green_col[i] = 8'h00;
      end
      emit_frame(1'b1);
   endfunction

   function automatic void predict_bus_beats(blmr_pkg::req_type r);
      beat_no = 0;
      case (blmr_pkg::action_type'(r.action))
         blmr_pkg::ACT_DRAW: begin
            if (r.column < NUM_COLS && r.row < NUM_ROWS) begin
               red_col[r.column][r.row[2:0]] = r.color[0];
               green_col[r.column][r.row[2:0]] = r.color[1];
            end
         end
         blmr_pkg::ACT_CLEAR: begin
            beat_total = 18 * BP;
            wipe_and_emit();
         end
         blmr_pkg::ACT_FRAME: begin
            beat_total = 18 * BP;
            emit_frame(1'b0);
         end
         default: begin
            beat_total = 24 * BP;
            for (int bp = 0; bp < BP; bp++) begin
               push_beat(bus_addr(bp), 1'b1, 1'b0);
               push_beat({blmr_pkg::CMD_OSC, blmr_pkg::VAL_ON}, 1'b0, 1'b1);
               push_beat(bus_addr(bp), 1'b1, 1'b0);
               push_beat({blmr_pkg::CMD_DISP, blmr_pkg::VAL_ON}, 1'b0, 1'b1);
               push_beat(bus_addr(bp), 1'b1, 1'b0);
               push_beat({blmr_pkg::CMD_DIM, dim_level}, 1'b0, 1'b1);
            end
            wipe_and_emit();
         end
      endcase
   endfunction

   function automatic void add_item(blmr_pkg::action_type a, int col, int row, int color,
                                    bit drain = 1'b0);
      stim_type it;
      it.req.action = a;
      it.req.column = 5'(col);
      it.req.row = 4'(row);
      it.req.color = 2'(color);
      it.drain_first = drain;
      pending_q.push_back(it);
   endfunction

   function automatic void add_random_item();
      int pick;
      blmr_pkg::action_type a;
      int col;
      int row;
      pick = $urandom_range(0, 99);
      if (pick < 70) a = blmr_pkg::ACT_DRAW;
      else if (pick < 88) a = blmr_pkg::ACT_FRAME;
      else if (pick < 94) a = blmr_pkg::ACT_CLEAR;
      else a = blmr_pkg::ACT_INIT;
      col = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 15);
      row = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
      add_item(a, col, row, $urandom_range(0, 3), $urandom_range(0, 99) < 3);
   endfunction

   function automatic void flag_beat(string what, blmr_pkg::rsp_type want,
                                     blmr_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: want %02h s%0b p%0b l%0b, got %02h s%0b p%0b l%0b", what,
                  want.bus_byte, want.start_before, want.stop_after, want.last,
                  got.bus_byte, got.start_before, got.stop_after, got.last);
   endfunction

   // driver
   always @(posedge clock) begin
      stim_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_bus_beats(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
                !(pending_q[0].drain_first && bus_beat_q.size() != 0)) begin
               it = pending_q.pop_front();
               req_data <= it.req;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      blmr_pkg::rsp_type want;
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_beat_q.size() == 0) begin
            flag_beat("unexpected beat", '0, rsp_data);
         end else begin
            want = bus_beat_q.pop_front();
            if (rsp_data.bus_byte !== want.bus_byte ||
                rsp_data.start_before !== want.start_before ||
                rsp_data.stop_after !== want.stop_after ||
                rsp_data.last !== want.last)
               flag_beat("beat mismatch", want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("FAIL bicolor_led_matrix_refresh_top");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || bus_beat_q.size() != 0)
         @(posedge clock);
      // a trailing draw gives no beat; let it settle
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] mask_v, logic [7:0] bright_v);
      csr_we <= 1'b1;
      csr_index <= blmr_pkg::CSR_GREEN_MASK;
      csr_wdata <= mask_v;
      @(posedge clock);
      invert_mask = mask_v;
      csr_index <= blmr_pkg::CSR_BRIGHTNESS;
      csr_wdata <= bright_v;
      @(posedge clock);
      dim_level = bright_v[3:0];
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_item(blmr_pkg::ACT_FRAME, 0, 0, 0);
      add_item(blmr_pkg::ACT_DRAW, 0, 0, 3);
      add_item(blmr_pkg::ACT_DRAW, 15, 7, 1);
      add_item(blmr_pkg::ACT_DRAW, 8, 7, 2);
      add_item(blmr_pkg::ACT_DRAW, 7, 0, 3);
      add_item(blmr_pkg::ACT_DRAW, 16, 0, 3);   // column past the last backpack
      add_item(blmr_pkg::ACT_DRAW, 31, 15, 3);
      add_item(blmr_pkg::ACT_DRAW, 3, 8, 3);    // row past the matrix
      add_item(blmr_pkg::ACT_DRAW, 3, 15, 2);
      add_item(blmr_pkg::ACT_FRAME, 31, 15, 3);
      add_item(blmr_pkg::ACT_DRAW, 0, 0, 0);
      add_item(blmr_pkg::ACT_FRAME, 0, 0, 0, 1'b1);
      add_item(blmr_pkg::ACT_INIT, 0, 0, 0);
      add_item(blmr_pkg::ACT_FRAME, 0, 0, 0);
      wait_idle();

      set_config(8'hFF, 8'h0F);
      add_item(blmr_pkg::ACT_DRAW, 5, 4, 3);
      add_item(blmr_pkg::ACT_FRAME, 0, 0, 0);
      add_item(blmr_pkg::ACT_INIT, 0, 0, 0);
      add_item(blmr_pkg::ACT_DRAW, 9, 2, 1);
      add_item(blmr_pkg::ACT_CLEAR, 0, 0, 0);
      add_item(blmr_pkg::ACT_FRAME, 0, 0, 0);
      wait_idle();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               gap_pct = 26;
               stall_pct = 81;
               set_config(8'h00, 8'h00);
            end
            1: begin
               gap_pct = 81;
               stall_pct = 26;
               set_config(8'($urandom), 8'($urandom));
            end
            default: begin
               gap_pct = 0;
               stall_pct = 0;
               set_config(8'hFF, 8'hF7);  // upper bits of brightness dropped
            end
         endcase
         repeat (140) add_random_item();
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS bicolor_led_matrix_refresh_top");
      else
         $display("FAIL bicolor_led_matrix_refresh_top");
      $finish;
   end

endmodule
